@@ rtl/pts_pkg.sv @@
package pts_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  typedef enum logic [3:0] {
    OP_FREE = 4'd0, OP_BYID = 4'd1, OP_NEXT = 4'd2, OP_COUNTSLEEP = 4'd3,
    OP_CLEAR = 4'd4, OP_READY = 4'd5, OP_BLOCK = 4'd6, OP_ZOMBIECHILD = 4'd7,
    OP_HASCHILD = 4'd8, OP_WAKEPARENT = 4'd9, OP_WAKESLEEP = 4'd10,
    OP_WAKECHAN = 4'd11, OP_WAKEFIRST = 4'd12, OP_WRITE = 4'd13,
    OP_BAD14 = 4'd14, OP_BAD15 = 4'd15
  } op_t;

  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_ZOMBIE  = 3'd4;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_SLEEP = 2'd1;
  localparam logic [1:0] WR_CHILD = 2'd2;
  localparam logic [1:0] WR_CHAN  = 2'd3;

  typedef struct packed {
    logic [2:0]  life;
    logic [31:0] tid;
    logic [31:0] pid;
    logic [1:0]  wkind;
    logic [31:0] wchan;
    logic [63:0] wake_at;
    logic [31:0] child;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

endpackage

@@ rtl/pts_ram.sv @@
module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

@@ rtl/process_table_scheduler_unit.sv @@
// process table scheduler: one table operation per input beat
// input channel: in_valid / in_stall with one port per field; result channel
// out_valid / out_stall carrying found, found_slot and woken, one result beat
// per input beat, in order.
// the slot table sits in one ram (one read, one write port, registered read).
// after reset the block first sweeps the ram, one slot a cycle, writing the
// cleared record, with in_stall high meanwhile. clear, ready, block and
// write then touch only one slot; every other operation walks all slots:
// one read issued per cycle, the returned record checked and, if it
// changes, written back in the same cycle. the next item is taken in the
// cycle after the result is loaded, so the block does not take a new item
// before it is through with the last one; the walk is paced by the single
// ram read port.
// round-robin scans (next, wakefirst) start after the current slot, or at
// slot 0 with no current; searches stop updating on the first hit but still
// finish the walk. while the receiver stalls, the result holds; one more
// item is still taken and walked, then waits with in_stall high until the result drains.
module process_table_scheduler_unit
  import pts_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic        in_no_current,
  input  logic [31:0] in_task_id,
  input  logic [31:0] in_parent_id,
  input  logic [31:0] in_target_id,
  input  logic [1:0]  in_reason,
  input  logic [31:0] in_channel,
  input  logic [63:0] in_tick,
  input  logic [2:0]  in_new_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [3:0]  out_found_slot,
  output logic [4:0]  out_woken
);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_INIT = 4'b0001, S_IDLE = 4'b0010, S_SCAN = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // reads issued
  logic [AW-1:0] raddr_r, raddr_nxt;   // next slot to read
  logic        chk_r, chk_nxt;          // read data valid this cycle
  logic [AW-1:0] chk_addr_r, chk_addr_nxt;
  logic        hit_r, hit_nxt;
  logic [AW-1:0] hit_slot_r, hit_slot_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [3:0]  kind_r;
  logic [3:0]  slot_r;
  logic [31:0] tid_r, pid_r, target_r, chan_r;
  logic [1:0]  reason_r;
  logic [63:0] tick_r;
  logic [2:0]  nst_r;

  logic        ov_r;
  logic        found_r;
  logic [3:0]  fslot_r;
  logic [4:0]  woken_r;

  logic        wr_en;
  logic [AW-1:0] wr_addr;
  slot_rec_t   wr_data, rd_data, rec, upd;

  // last write forwarded when the same slot is read in the same cycle as it is written
  logic        fwd_r;
  slot_rec_t   fwd_data_r;

  pts_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (raddr_r),
    .rd_data (rd_data)
  );

  logic accept, out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE);
  assign accept   = in_valid && !in_stall;

  logic        in_range;
  logic [AW-1:0] start;
  logic [AW-1:0] start_tbl [16];
  assign in_range = ({28'd0, slot_r} < 32'(SLOTS));

  // round-robin start for each slot value, wrapped at the table size
  for (genvar g = 0; g < 16; g++) begin : g_start
    assign start_tbl[g] = AW'((g + 1) % SLOTS);
  end
  assign start = in_no_current ? '0 : start_tbl[in_slot];

  slot_rec_t clr_rec;
  assign clr_rec = '{life: ST_UNUSED, tid: '0, pid: '0, wkind: WR_NONE,
                     wchan: '0, wake_at: '0, child: '0};

  function automatic slot_rec_t woke(slot_rec_t r);
    slot_rec_t o;
    o = r;
    o.life = ST_READY;
    o.wkind = WR_NONE;
    o.wchan = '0;
    o.wake_at = '0;
    o.child = '0;
    return o;
  endfunction

  logic match, do_wr, child_m, chan_m;
  always_comb begin
    rec = (fwd_r) ? fwd_data_r : rd_data;
    upd = rec;
    match = 1'b0;
    do_wr = 1'b0;
    child_m = (rec.life != ST_UNUSED) && (pid_r != '0) && (rec.pid == pid_r) &&
              ((target_r == '0) || (rec.tid == target_r));
    chan_m = (rec.life == ST_BLOCKED) && (rec.wkind == WR_CHAN) && (rec.wchan == chan_r);
    case (op_t'(kind_r))
      OP_FREE:        match = (rec.life == ST_UNUSED);
      OP_BYID:        match = (tid_r != '0) && (rec.life != ST_UNUSED) && (rec.tid == tid_r);
      OP_NEXT:        match = (rec.life == ST_READY);
      OP_COUNTSLEEP:  match = (rec.life == ST_BLOCKED) && (rec.wkind == WR_SLEEP);
      OP_ZOMBIECHILD: match = child_m && (rec.life == ST_ZOMBIE);
      OP_HASCHILD:    match = child_m;
      OP_WAKEPARENT: begin
        match = (rec.life == ST_BLOCKED) && (rec.wkind == WR_CHILD) &&
                ((rec.child == '0) || (rec.child == tid_r));
        do_wr = match;
        upd = woke(rec);
      end
      OP_WAKESLEEP: begin
        match = (rec.life == ST_BLOCKED) && (rec.wkind == WR_SLEEP) && (rec.wake_at <= tick_r);
        do_wr = match;
        upd = woke(rec);
      end
      OP_WAKECHAN: begin
        match = chan_m;
        do_wr = match;
        upd = woke(rec);
      end
      OP_WAKEFIRST: begin
        match = chan_m && !hit_r;
        do_wr = match;
        upd = woke(rec);
      end
      OP_CLEAR, OP_READY, OP_BLOCK, OP_WRITE: begin
        // only the target slot is read for these
        do_wr = 1'b1;
        case (op_t'(kind_r))
          OP_CLEAR: upd = clr_rec;
          OP_READY: upd = (rec.life == ST_BLOCKED) ? woke(rec) : rec;
          OP_BLOCK: begin
            upd.life = ST_BLOCKED;
            upd.wkind = reason_r;
            upd.wchan = chan_r;
            upd.wake_at = tick_r;
            upd.child = target_r;
          end
          default: begin
            upd.tid = tid_r;
            upd.pid = pid_r;
            upd.life = (nst_r <= ST_ZOMBIE) ? nst_r : ST_UNUSED;
          end
        endcase
      end
      default: match = 1'b0;
    endcase
  end

  logic single_op;
  assign single_op = (kind_r == OP_CLEAR) || (kind_r == OP_READY) ||
                     (kind_r == OP_BLOCK) || (kind_r == OP_WRITE);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = chk_addr_r;
    wr_data = upd;
    if (state_r == S_INIT) begin
      wr_en = 1'b1;
      wr_addr = raddr_r;
      wr_data = clr_rec;
    end else if (state_r == S_SCAN && chk_r && do_wr) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    raddr_nxt = raddr_r;
    chk_nxt = 1'b0;
    chk_addr_nxt = raddr_r;
    hit_nxt = hit_r;
    hit_slot_nxt = hit_slot_r;
    count_nxt = count_r;
    case (state_r)
      S_INIT: begin
        raddr_nxt = (raddr_r == AW'(SLOTS - 1)) ? '0 : raddr_r + 1'b1;
        if (raddr_r == AW'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          cnt_nxt = '0;
          hit_nxt = 1'b0;
          hit_slot_nxt = '0;
          count_nxt = '0;
          raddr_nxt = ((in_kind == OP_NEXT) || (in_kind == OP_WAKEFIRST)) ? start :
                      AW'(in_slot);
          if (!((in_kind == OP_NEXT) || (in_kind == OP_WAKEFIRST) ||
                (in_kind == OP_CLEAR) || (in_kind == OP_READY) ||
                (in_kind == OP_BLOCK) || (in_kind == OP_WRITE))) begin
            raddr_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (single_op) begin
          if (cnt_r == '0) begin
            if (in_range) begin
              cnt_nxt = cnt_r + 1'b1;
              chk_nxt = 1'b1;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (chk_r) begin
            state_nxt = S_DONE;
          end
        end else begin
          if (cnt_r != CW'(SLOTS)) begin
            cnt_nxt = cnt_r + 1'b1;
            chk_nxt = 1'b1;
            raddr_nxt = (raddr_r == AW'(SLOTS - 1)) ? '0 : raddr_r + 1'b1;
          end else if (!chk_r) begin
            state_nxt = S_DONE;
          end
        end
        if (chk_r && match) begin
          if (!hit_r) hit_slot_nxt = chk_addr_r;
          hit_nxt = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      raddr_r <= '0;
      cnt_r <= '0;
      chk_r <= 1'b0;
      hit_r <= 1'b0;
      count_r <= '0;
      ov_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      raddr_r <= raddr_nxt;
      cnt_r <= cnt_nxt;
      chk_r <= chk_nxt;
      hit_r <= hit_nxt;
      count_r <= count_nxt;
      fwd_r <= wr_en && (wr_addr == raddr_r);
      if (state_r == S_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  logic [4:0] woken_v;
  logic [CW:0] count_x;
  assign count_x = {1'b0, count_r};
  assign woken_v = (count_x > (CW+1)'(31)) ? 5'd31 : 5'(count_x);

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    hit_slot_r <= hit_slot_nxt;
    fwd_data_r <= wr_data;
    if (accept) begin
      kind_r <= in_kind;
      slot_r <= in_slot;
      tid_r <= in_task_id;
      pid_r <= in_parent_id;
      target_r <= in_target_id;
      chan_r <= in_channel;
      reason_r <= in_reason;
      tick_r <= in_tick;
      nst_r <= in_new_state;
    end
    if (state_r == S_DONE && out_free) begin
      found_r <= 1'b0;
      fslot_r <= '0;
      woken_r <= '0;
      case (op_t'(kind_r))
        OP_FREE, OP_BYID, OP_NEXT, OP_ZOMBIECHILD: begin
          found_r <= hit_r;
          fslot_r <= 4'(hit_slot_r);
        end
        OP_HASCHILD: found_r <= hit_r;
        OP_COUNTSLEEP, OP_WAKEPARENT, OP_WAKESLEEP, OP_WAKECHAN: begin
          found_r <= hit_r;
          woken_r <= woken_v;
        end
        OP_WAKEFIRST: begin
          found_r <= hit_r;
          fslot_r <= 4'(hit_slot_r);
          woken_r <= {4'd0, hit_r};
        end
        OP_CLEAR, OP_READY, OP_BLOCK, OP_WRITE: begin
          found_r <= in_range;
          fslot_r <= in_range ? slot_r : 4'd0;
        end
        default: found_r <= 1'b0;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_found      = found_r;
  assign out_found_slot = fslot_r;
  assign out_woken      = woken_r;

  a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SCAN)
    else $error("accept outside idle");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !wr_en)
    else $error("table written while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(found_r) && $stable(woken_r))
    else $error("result lost under stall");
endmodule
